// ===== design/spdc_pkg.sv =====
// Package: shared types, status codes and the fixed command pattern table.
`default_nettype none
package spdc_pkg;

	localparam int MAX_PACKET_DEF = 16;
	localparam int MIN_PACKET     = 3;
	localparam int TABLE_SIZE     = 37;
	localparam int PREFIX_LEN     = 4;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] HEADER_MASK = 8'h80;
	localparam logic [7:0] TERMINATOR  = 8'hFF;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_OVERFLOW   = 3'd2,
		ST_TIMEOUT    = 3'd3,
		ST_SHORT      = 3'd4
	} status_t;

	// One finished packet as handed from the deframer to the classifier.
	typedef struct packed {
		status_t               status;
		logic [4:0]            len;
		logic [3:0]            msg_type;
		logic [TABLE_SIZE-1:0] hits;
	} event_t;

	// Prefix bytes compared against packet bytes 1 to 4.
	localparam logic [7:0] TBL_PAT [TABLE_SIZE][PREFIX_LEN] = '{
		'{8'h01, 8'h00, 8'h01, 8'h00}, '{8'h01, 8'h04, 8'h00, 8'h00},
		'{8'h01, 8'h04, 8'h07, 8'h00}, '{8'h01, 8'h04, 8'h08, 8'h00},
		'{8'h01, 8'h04, 8'h0B, 8'h00}, '{8'h01, 8'h04, 8'h10, 8'h05},
		'{8'h01, 8'h04, 8'h18, 8'h01}, '{8'h01, 8'h04, 8'h35, 8'h00},
		'{8'h01, 8'h04, 8'h36, 8'h00}, '{8'h01, 8'h04, 8'h38, 8'h00},
		'{8'h01, 8'h04, 8'h39, 8'h00}, '{8'h01, 8'h04, 8'h47, 8'h00},
		'{8'h01, 8'h04, 8'h62, 8'h00}, '{8'h01, 8'h04, 8'h74, 8'h03},
		'{8'h09, 8'h04, 8'h00, 8'h00}, '{8'h09, 8'h04, 8'h38, 8'h00},
		'{8'h09, 8'h04, 8'h48, 8'h00}, '{8'h09, 8'h04, 8'h39, 8'h00},
		'{8'h09, 8'h04, 8'h47, 8'h00}, '{8'h09, 8'h04, 8'h4B, 8'h00},
		'{8'h09, 8'h04, 8'h62, 8'h00}, '{8'h30, 8'h01, 8'h00, 8'h00},
		'{8'h77, 8'h01, 8'h00, 8'h00}, '{8'h77, 8'h02, 8'h00, 8'h00},
		'{8'h30, 8'h02, 8'h00, 8'h00}, '{8'h40, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h00, 8'h00, 8'h00}, '{8'h42, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h00, 8'h00, 8'h00}, '{8'h50, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h00, 8'h00, 8'h00}, '{8'h51, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h00, 8'h00, 8'h00}, '{8'h61, 8'h41, 8'h00, 8'h00},
		'{8'h62, 8'h41, 8'h00, 8'h00}, '{8'h61, 8'h00, 8'h00, 8'h00},
		'{8'h62, 8'h00, 8'h00, 8'h00}
	};

	// Payload length (packet length less header and terminator).
	localparam logic [7:0] TBL_LEN [TABLE_SIZE] = '{
		8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
		8'd4, 8'd7, 8'd4, 8'd4, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
		8'd3, 8'd2, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd5, 8'd2,
		8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2
	};

	// Number of prefix bytes that must match.
	localparam logic [7:0] TBL_CMP [TABLE_SIZE] = '{
		8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd3, 8'd4, 8'd3,
		8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
		8'd3, 8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd1, 8'd1
	};

endpackage
`default_nettype wire

// ===== design/spdc_if.sv =====
// Interfaces: the input word channel and the result word channel.
`default_nettype none
interface spdc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;
	modport source (output valid, operation, rx_byte, input ready);
	modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface spdc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [4:0] packet_length;
	logic [3:0] message_type;
	logic [5:0] command_id;
	modport source (output valid, status, packet_length, message_type, command_id,
		input ready);
	modport sink (input valid, status, packet_length, message_type, command_id,
		output ready);
endinterface
`default_nettype wire

// ===== design/serial_packet_deframer_classifier.sv =====
// Top level: serial packet deframer and command classifier.
// Usage: in_ch carries one word per handshake, either a received byte (operation 0)
// or a time tick (operation 1). out_ch gives one result word per finished,
// rejected, overflowed or timed-out packet: status, length, message type and
// the matched command number (0 when nothing matches).
// cfg_we/cfg_wdata write timeout_ticks; write it only while the block is idle.
// Throughput: one input word per cycle while the event queue is not full. A result
// word goes into the event queue at the edge that accepts the word closing the packet,
// and from the queue into the output register that drives out_ch.
// Pattern matching is done as bytes arrive, so the classifier only does a
// priority pick over 37 flags.
// When out_ch stalls, results collect in the two-entry event queue and in the
// output register; in_ch.ready drops only when the queue is full.
// Reset clears the packet state, the queue and the output valid; timeout_ticks
// resets to zero, which disables the timeout.
`default_nettype none
module serial_packet_deframer_classifier #(
	parameter int MAX_PACKET = spdc_pkg::MAX_PACKET_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	spdc_in_if.sink      in_ch,
	spdc_out_if.source   out_ch,
	input  wire          cfg_we,
	input  wire [15:0]   cfg_wdata
);
	import spdc_pkg::*;

	logic        q_full, q_not_empty, push, pop, acc;
	event_t      ev, q_data;
	logic [15:0] timeout_q;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && !q_full;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= '0;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	spdc_front #(.MAX_PACKET(MAX_PACKET)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.operation     (in_ch.operation),
		.rx_byte       (in_ch.rx_byte),
		.timeout_ticks (timeout_q),
		.q_full        (q_full),
		.push          (push),
		.ev            (ev)
	);

	spdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (ev),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_data   (q_data)
	);

	spdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.pop         (pop),
		.out_ch      (out_ch)
	);
endmodule
`default_nettype wire

// ===== design/spdc_front.sv =====
// Front end: deframes bytes and ticks, tracks per-pattern match flags, raises events.
`default_nettype none
module spdc_front #(
	parameter int MAX_PACKET = spdc_pkg::MAX_PACKET_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  acc,
	input  wire                  operation,
	input  wire  [7:0]           rx_byte,
	input  wire  [15:0]          timeout_ticks,
	input  wire                  q_full,
	output logic                 push,
	output spdc_pkg::event_t     ev
);
	import spdc_pkg::*;

	localparam int POS_W = $clog2(MAX_PACKET + 1);

	logic                  in_pkt_q, in_pkt_n;
	logic [POS_W-1:0]      pos_q, pos_n, pos_eff, count;
	logic [15:0]           gap_q, gap_n, gap_inc;
	logic [3:0]            type_q, type_n;
	logic [TABLE_SIZE-1:0] flags_q, flags_n, flags_upd, len_hit;
	logic                  opening;

	assign gap_inc = (gap_q != 16'hFFFF) ? gap_q + 16'd1 : gap_q;
	assign opening = !in_pkt_q;
	assign pos_eff = opening ? '0 : pos_q;
	assign count   = pos_eff + POS_W'(1);

	// Clear a pattern's flag when a byte at one of its compared positions differs; flag length hits.
	always_comb begin
		for (int e = 0; e < TABLE_SIZE; e++) begin
			flags_upd[e] = opening ? 1'b1 : flags_q[e];
			if (int'(TBL_CMP[e]) >= MAX_PACKET)
				flags_upd[e] = 1'b0;
			for (int k = 0; k < PREFIX_LEN; k++) begin
				if (k < int'(TBL_CMP[e]) && int'(pos_eff) == k + 1
						&& rx_byte != TBL_PAT[e][k])
					flags_upd[e] = 1'b0;
			end
			len_hit[e] = (8'(count) == TBL_LEN[e] + 8'd2);
		end
	end

	// Next state and event generation for one accepted word.
	always_comb begin
		in_pkt_n    = in_pkt_q;
		pos_n       = pos_q;
		gap_n       = gap_q;
		type_n      = type_q;
		flags_n     = flags_q;
		push        = 1'b0;
		ev.status   = ST_OK;
		ev.len      = '0;
		ev.msg_type = '0;
		ev.hits     = '0;
		if (acc) begin
			if (operation) begin
				if (in_pkt_q && timeout_ticks != 16'd0) begin
					gap_n = gap_inc;
					if (gap_inc >= timeout_ticks) begin
						push      = 1'b1;
						ev.status = ST_TIMEOUT;
						ev.len    = 5'(pos_q);
						in_pkt_n  = 1'b0;
						pos_n     = '0;
						gap_n     = '0;
					end
				end
			end else if (opening && (rx_byte & HEADER_MASK) == 8'h00) begin
				push      = 1'b1;
				ev.status = ST_BAD_HEADER;
				ev.len    = 5'd1;
			end else begin
				flags_n = flags_upd;
				gap_n   = '0;
				if (int'(pos_eff) == 1)
					type_n = rx_byte[7:4];
				if (rx_byte == TERMINATOR) begin
					push     = 1'b1;
					ev.len   = 5'(count);
					in_pkt_n = 1'b0;
					pos_n    = '0;
					if (int'(count) < MIN_PACKET) begin
						ev.status = ST_SHORT;
					end else begin
						ev.status   = ST_OK;
						ev.msg_type = type_q;
						ev.hits     = flags_upd & len_hit;
					end
				end else if (int'(count) >= MAX_PACKET) begin
					push      = 1'b1;
					ev.status = ST_OVERFLOW;
					ev.len    = 5'(count);
					in_pkt_n  = 1'b0;
					pos_n     = '0;
				end else begin
					in_pkt_n = 1'b1;
					pos_n    = count;
				end
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
			gap_q    <= '0;
		end else begin
			in_pkt_q <= in_pkt_n;
			pos_q    <= pos_n;
			gap_q    <= gap_n;
		end
	end

	// Payload state: message type and match flags.
	always_ff @(posedge clk) begin
		type_q  <= type_n;
		flags_q <= flags_n;
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pkt_q |-> (pos_q == '0 && gap_q == '0))
		else $error("idle deframer holds stale position or gap count");
	a_open_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_pkt_q |-> (pos_q != '0 && int'(pos_q) < MAX_PACKET))
		else $error("open packet position out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("event raised while queue full");
endmodule
`default_nettype wire

// ===== design/spdc_queue.sv =====
// Short queue between the deframer and the classifier.
`default_nettype none
module spdc_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  spdc_pkg::event_t  wr_data,
	input  wire               pop,
	output logic              full,
	output logic              not_empty,
	output spdc_pkg::event_t  rd_data
);
	import spdc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	event_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     cnt_q;

	assign full      = (int'(cnt_q) == QUEUE_DEPTH);
	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== design/spdc_back.sv =====
// Back end: picks the first matching pattern and holds the result word.
`default_nettype none
module spdc_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_not_empty,
	input  spdc_pkg::event_t  q_data,
	output logic              pop,
	spdc_out_if.source        out_ch
);
	import spdc_pkg::*;

	logic       valid_q;
	logic [5:0] id;

	assign pop = q_not_empty && (!valid_q || out_ch.ready);

	// Priority pick of the lowest matching entry, numbered from one.
	always_comb begin
		id = '0;
		for (int e = TABLE_SIZE - 1; e >= 0; e--) begin
			if (q_data.hits[e])
				id = 6'(e + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ch.ready)
			valid_q <= 1'b0;
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_ch.status        <= q_data.status;
			out_ch.packet_length <= q_data.len;
			out_ch.message_type  <= q_data.msg_type;
			out_ch.command_id    <= id;
		end
	end

	assign out_ch.valid = valid_q;
endmodule
`default_nettype wire
